[rtl/core/pdsc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// pdsc_pkg
// Shared types, widths and tables of the PLL divider setting calculator.
// ============================================================================
package pdsc_pkg;

    localparam int unsigned CRYSTAL_W    = 16;
    localparam int unsigned FREQ_W       = 22;
    localparam int unsigned BW_W         = 4;
    localparam int unsigned VCO_W        = 24;    // 4 * max frequency fits
    localparam int unsigned FRAC_W       = 15;
    localparam int unsigned WORD_W       = VCO_W + FRAC_W;
    localparam int unsigned DIV_STEPS    = WORD_W;
    localparam int unsigned HALF_W       = CRYSTAL_W - 1;
    localparam int unsigned QTR_W        = CRYSTAL_W - 2;
    localparam int unsigned REM_W        = HALF_W;
    localparam int unsigned SEL_W        = 4;
    localparam int unsigned NUM_MULT     = 10;
    localparam int unsigned ROUND_STEP   = VCO_W - 1;

    localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 16'd28800;
    localparam int unsigned          VCO_LIMIT     = 3560000;

    localparam logic [6:0] MULT_TAB [NUM_MULT] = '{
        7'd96, 7'd64, 7'd48, 7'd32, 7'd24, 7'd16, 7'd12, 7'd8, 7'd6, 7'd4
    };

    // Largest frequency whose product with each multiplier stays below the limit
    localparam logic [FREQ_W-1:0] F_MAX [NUM_MULT-1] = '{
        22'((VCO_LIMIT - 1) / 96), 22'((VCO_LIMIT - 1) / 64),
        22'((VCO_LIMIT - 1) / 48), 22'((VCO_LIMIT - 1) / 32),
        22'((VCO_LIMIT - 1) / 24), 22'((VCO_LIMIT - 1) / 16),
        22'((VCO_LIMIT - 1) / 12), 22'((VCO_LIMIT - 1) / 8),
        22'((VCO_LIMIT - 1) / 6)
    };

    localparam logic [7:0] ODIV_TAB [NUM_MULT/2] = '{
        8'h82, 8'h42, 8'h22, 8'h12, 8'h0A
    };

    localparam logic [7:0] MODE_DIV3      = 8'h02;
    localparam logic [7:0] MODE_HIGH_BAND = 8'h08;

    // Bandwidth code placed in mode bits 7:6
    localparam logic [1:0] BW_CODE_6MHZ = 2'b10;
    localparam logic [1:0] BW_CODE_7MHZ = 2'b01;
    localparam logic [1:0] BW_CODE_8MHZ = 2'b00;
    localparam logic [BW_W-1:0] BW_SEL_6 = 4'd6;
    localparam logic [BW_W-1:0] BW_SEL_7 = 4'd7;

    typedef struct packed {
        logic [WORD_W-1:0] word;     // dividend bits shift out, quotient bits in
        logic [REM_W-1:0]  rem;
        logic              rnd;
        logic [SEL_W-1:0]  sel;
        logic [1:0]        bw_code;
    } pipe_t;

    typedef struct packed {
        logic [3:0] count_nine_cycles;
        logic [7:0] total_cycles;
        logic [7:0] fraction_high;
        logic [7:0] fraction_low;
        logic [7:0] output_divider;
        logic [7:0] mode_byte;
        logic [6:0] vco_multiplier;
    } res_t;

endpackage

[rtl/core/pdsc_mult_sel.sv]
`timescale 1ns / 1ps
// ============================================================================
// pdsc_mult_sel
// Multiplier choice, VCO value and bandwidth code of one request.
// ============================================================================
module pdsc_mult_sel (
    input  logic [pdsc_pkg::FREQ_W-1:0] frequency_khz,
    input  logic [pdsc_pkg::BW_W-1:0]   bandwidth_mhz,
    output pdsc_pkg::pipe_t             pipe_out
);

    logic [pdsc_pkg::SEL_W-1:0]        sel;
    logic [pdsc_pkg::FREQ_W+6:0]       prod;
    logic [1:0]                        bw_code;

    // Take the lowest index whose threshold still holds; fall back to the last
    always_comb begin
        sel = pdsc_pkg::SEL_W'(pdsc_pkg::NUM_MULT - 1);
        for (int i = pdsc_pkg::NUM_MULT - 2; i >= 0; i--) begin
            if (frequency_khz <= pdsc_pkg::F_MAX[i]) begin
                sel = pdsc_pkg::SEL_W'(i);
            end
        end
    end

    assign prod = (pdsc_pkg::FREQ_W+7)'(frequency_khz)
                * (pdsc_pkg::FREQ_W+7)'(pdsc_pkg::MULT_TAB[sel]);

    always_comb begin
        unique case (bandwidth_mhz)
            pdsc_pkg::BW_SEL_6: bw_code = pdsc_pkg::BW_CODE_6MHZ;
            pdsc_pkg::BW_SEL_7: bw_code = pdsc_pkg::BW_CODE_7MHZ;
            default:            bw_code = pdsc_pkg::BW_CODE_8MHZ;
        endcase
    end

    always_comb begin
        pipe_out         = '0;
        pipe_out.word    = {prod[pdsc_pkg::VCO_W-1:0], {pdsc_pkg::FRAC_W{1'b0}}};
        pipe_out.sel     = sel;
        pipe_out.bw_code = bw_code;
    end

endmodule

[rtl/core/pdsc_div_step.sv]
`timescale 1ns / 1ps
// ============================================================================
// pdsc_div_step
// One restoring division step: one quotient bit against half the crystal.
// ============================================================================
module pdsc_div_step (
    input  pdsc_pkg::pipe_t             pipe_in,
    input  logic [pdsc_pkg::HALF_W-1:0] half,
    input  logic [pdsc_pkg::QTR_W-1:0]  quarter,
    input  logic                        round_point,
    output pdsc_pkg::pipe_t             pipe_out
);

    logic [pdsc_pkg::REM_W:0]   trial;
    logic                       ge;
    logic [pdsc_pkg::REM_W:0]   diff;
    logic [pdsc_pkg::REM_W-1:0] rem_next;

    assign trial    = {pipe_in.rem, pipe_in.word[pdsc_pkg::WORD_W-1]};
    assign ge       = trial >= {1'b0, half};
    assign diff     = trial - {1'b0, half};
    assign rem_next = ge ? diff[pdsc_pkg::REM_W-1:0] : trial[pdsc_pkg::REM_W-1:0];

    always_comb begin
        pipe_out      = pipe_in;
        pipe_out.word = {pipe_in.word[pdsc_pkg::WORD_W-2:0], ge};
        pipe_out.rem  = rem_next;
        // After the last integer bit the remainder is exact: latch the round-up
        if (round_point) begin
            pipe_out.rnd = rem_next >= pdsc_pkg::REM_W'(quarter);
        end
    end

endmodule

[rtl/core/pdsc_pack.sv]
`timescale 1ns / 1ps
// ============================================================================
// pdsc_pack
// Rounds the quotient and packs the PLL register bytes.
// ============================================================================
module pdsc_pack (
    input  pdsc_pkg::pipe_t pipe_in,
    output pdsc_pkg::res_t  res_out
);

    logic [pdsc_pkg::VCO_W-1:0]  quo;
    logic [pdsc_pkg::FRAC_W-1:0] frac;
    logic [15:0]                 xdiv;
    logic [2:0]                  am;
    logic [7:0]                  pm;

    assign quo  = pipe_in.word[pdsc_pkg::WORD_W-1:pdsc_pkg::FRAC_W];
    assign frac = pipe_in.word[pdsc_pkg::FRAC_W-1:0];
    assign xdiv = quo[15:0] + 16'(pipe_in.rnd);
    assign am   = xdiv[2:0];
    assign pm   = xdiv[10:3];

    always_comb begin
        if (am < 3'd2) begin
            res_out.count_nine_cycles = {1'b1, am};
            res_out.total_cycles      = pm - 8'd1;
        end else begin
            res_out.count_nine_cycles = {1'b0, am};
            res_out.total_cycles      = pm;
        end
        // Bit 15 mirrors bit 14: set once the fraction reaches half scale
        res_out.fraction_high  = {frac[14], frac[14:8]};
        res_out.fraction_low   = frac[7:0];
        res_out.output_divider = pdsc_pkg::ODIV_TAB[pipe_in.sel[3:1]];
        res_out.mode_byte      = {pipe_in.bw_code, 6'd0} | pdsc_pkg::MODE_HIGH_BAND
                               | (pipe_in.sel[0] ? pdsc_pkg::MODE_DIV3 : 8'h00);
        res_out.vco_multiplier = pdsc_pkg::MULT_TAB[pipe_in.sel];
    end

endmodule

[rtl/core/pll_divider_setting_calc.sv]
`timescale 1ns / 1ps
// ============================================================================
// pll_divider_setting_calc
// Fractional-N tuner PLL divider calculator, fully pipelined.
// ============================================================================
// The block accepts one tuning request per clock while the output is not held
// back and returns one result per request, in order. In the divider the VCO
// value is divided by half the crystal frequency one quotient bit per stage,
// 24 integer bits followed by 15 fraction bits, 39 stages in all. One stage
// ahead of it picks the multiplier and forms the VCO value, and the output
// register behind it packs the register bytes. Each stage has its own valid
// bit and advances whenever the stage after it is empty or moving, so bubbles
// close up while the output waits. Write cfg_crystal_khz only with the
// pipeline empty.
// ============================================================================
module pll_divider_setting_calc (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_crystal_khz,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [21:0] s_frequency_khz,
    input  logic [3:0]  s_bandwidth_mhz,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_count_nine_cycles,
    output logic [7:0]  m_total_cycles,
    output logic [7:0]  m_fraction_high,
    output logic [7:0]  m_fraction_low,
    output logic [7:0]  m_output_divider,
    output logic [7:0]  m_mode_byte,
    output logic [6:0]  m_vco_multiplier
);

    localparam int unsigned NUM_PIPE = pdsc_pkg::DIV_STEPS + 1;   // select + steps
    localparam int unsigned OUT_IDX  = NUM_PIPE;

    // ------------------------------------------------------------------
    // Configuration: the crystal register is always ready for a transaction
    // ------------------------------------------------------------------
    logic [pdsc_pkg::CRYSTAL_W-1:0] crystal_reg;
    logic [pdsc_pkg::HALF_W-1:0]    half;
    logic [pdsc_pkg::QTR_W-1:0]     quarter;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crystal_reg <= pdsc_pkg::CRYSTAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            crystal_reg <= cfg_crystal_khz;
        end
    end

    // Half the crystal, forced to one when the crystal is below 2 kHz
    always_comb begin
        half = crystal_reg[pdsc_pkg::CRYSTAL_W-1:1];
        if (half == '0) begin
            half = pdsc_pkg::HALF_W'(1);
        end
    end
    assign quarter = crystal_reg[pdsc_pkg::CRYSTAL_W-1:2];

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic [OUT_IDX:0]  valid_reg;
    logic [OUT_IDX:0]  stage_ready;

    genvar k;
    generate
        for (k = 0; k < OUT_IDX; k++) begin : g_ready
            assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    endgenerate
    assign stage_ready[OUT_IDX] = !valid_reg[OUT_IDX] || m_ready;
    assign s_ready              = stage_ready[0];

    // ------------------------------------------------------------------
    // Stage 0: multiplier selection and VCO value
    // ------------------------------------------------------------------
    pdsc_pkg::pipe_t pipe_reg  [NUM_PIPE];
    pdsc_pkg::pipe_t pipe_next [NUM_PIPE];

    pdsc_mult_sel u_mult_sel (
        .frequency_khz (s_frequency_khz),
        .bandwidth_mhz (s_bandwidth_mhz),
        .pipe_out      (pipe_next[0])
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (stage_ready[0]) begin
            valid_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            pipe_reg[0] <= pipe_next[0];
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..39: one restoring division step each
    // ------------------------------------------------------------------
    generate
        for (k = 1; k < NUM_PIPE; k++) begin : g_div
            pdsc_div_step u_step (
                .pipe_in     (pipe_reg[k-1]),
                .half        (half),
                .quarter     (quarter),
                .round_point (k - 1 == pdsc_pkg::ROUND_STEP),
                .pipe_out    (pipe_next[k])
            );

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end

            // Hold payload while stalled; advance otherwise
            always_ff @(posedge aclk) begin
                if (stage_ready[k]) begin
                    pipe_reg[k] <= pipe_next[k];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register: rounding and byte packing
    // ------------------------------------------------------------------
    pdsc_pkg::res_t res_next;
    pdsc_pkg::res_t res_reg;

    pdsc_pack u_pack (
        .pipe_in (pipe_reg[NUM_PIPE-1]),
        .res_out (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[OUT_IDX] <= 1'b0;
        end else if (stage_ready[OUT_IDX]) begin
            valid_reg[OUT_IDX] <= valid_reg[NUM_PIPE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[OUT_IDX]) begin
            res_reg <= res_next;
        end
    end

    assign m_valid             = valid_reg[OUT_IDX];
    assign m_count_nine_cycles = res_reg.count_nine_cycles;
    assign m_total_cycles      = res_reg.total_cycles;
    assign m_fraction_high     = res_reg.fraction_high;
    assign m_fraction_low      = res_reg.fraction_low;
    assign m_output_divider    = res_reg.output_divider;
    assign m_mode_byte         = res_reg.mode_byte;
    assign m_vco_multiplier    = res_reg.vco_multiplier;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted request always lands in the first stage
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted request did not enter the pipeline");

    // The partial remainder leaving the divider stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NUM_PIPE-1] |-> pipe_reg[NUM_PIPE-1].rem < half)
        else $error("division remainder out of range");

    // The count-to-9 field is always folded into the range 2..9
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_count_nine_cycles >= 4'd2) && (m_count_nine_cycles <= 4'd9))
        else $error("count-to-9 field out of range");

    // Divide-by-3 bit matches the multiplier, and the high band bit is set
    a_mode_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_mode_byte[3] && (m_mode_byte[1] ==
            (m_vco_multiplier == 7'd64 || m_vco_multiplier == 7'd32 ||
             m_vco_multiplier == 7'd16 || m_vco_multiplier == 7'd8 ||
             m_vco_multiplier == 7'd4)))
        else $error("mode byte inconsistent with multiplier");

endmodule

[dv/pll_divider_setting_calc_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// pll_divider_setting_calc_tb
// Self-checking testbench of the PLL divider setting calculator.
// ============================================================================
// Runs a short directed table at the reset crystal: zero frequency at every
// bandwidth, both sides of every multiplier boundary, the largest frequency
// and alternating bit patterns. Then it reprograms the crystal register
// several times, from zero and one up to the 16-bit maximum, and sends
// random tuning requests under each setting. Each accepted request without a
// typed result is run through a local model of the divider arithmetic. Every
// accepted result is checked in order against the oldest expectation. Both
// sides insert random wait states, with calm stretches between them.
// ============================================================================
module pll_divider_setting_calc_tb;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 5;
    localparam int MAX_WAIT        = 14;
    localparam int MAX_REPORTS     = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int DRAIN_CYCLES    = 60;      // comfortably past the pipeline latency
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DIR_ROWS        = 25;
    localparam int FIXED_PHASES    = 8;
    localparam int NUM_PHASES      = 10;

    // Multiplier ladder, largest first, and the divider byte of each pair
    localparam int unsigned VCO_MULT [pdsc_pkg::NUM_MULT] =
        '{96, 64, 48, 32, 24, 16, 12, 8, 6, 4};
    localparam logic [7:0]  ODIV_SEL [pdsc_pkg::NUM_MULT/2] =
        '{8'h82, 8'h42, 8'h22, 8'h12, 8'h0A};

    // Crystal settings walked after the directed table; two more are drawn at random
    localparam logic [15:0] CRYSTAL_PLAN [FIXED_PHASES] = '{
        16'd40000, 16'd8000, 16'd65535, 16'd0, 16'd1, 16'd100, 16'd3, 16'd28800
    };

    typedef struct {
        logic [pdsc_pkg::FREQ_W-1:0] freq;
        logic [pdsc_pkg::BW_W-1:0]   bw;
        bit                          typed;
        pdsc_pkg::res_t              want;
    } stim_row_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_crystal_khz = pdsc_pkg::CRYSTAL_RESET;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [21:0] s_frequency_khz = '0;
    logic [3:0]  s_bandwidth_mhz = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [3:0]  m_count_nine_cycles;
    logic [7:0]  m_total_cycles;
    logic [7:0]  m_fraction_high;
    logic [7:0]  m_fraction_low;
    logic [7:0]  m_output_divider;
    logic [7:0]  m_mode_byte;
    logic [6:0]  m_vco_multiplier;

    pdsc_pkg::res_t pending_settings [$];
    logic [15:0]    crystal_khz = pdsc_pkg::CRYSTAL_RESET;
    int             fail_count  = 0;
    int             cycle_count = 0;
    bit             send_calm   = 1'b0;
    bit             recv_calm   = 1'b0;

    // Directed table. Rows with a typed result are plain enough to read off
    // by hand (zero frequency at the reset crystal); the rest use the model.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{22'd0,       4'd0,  1'b1, '{4'd8, 8'd255, 8'h00, 8'h00, 8'h82, 8'h08, 7'd96}},
        '{22'd0,       4'd6,  1'b1, '{4'd8, 8'd255, 8'h00, 8'h00, 8'h82, 8'h88, 7'd96}},
        '{22'd0,       4'd7,  1'b1, '{4'd8, 8'd255, 8'h00, 8'h00, 8'h82, 8'h48, 7'd96}},
        '{22'd0,       4'd15, 1'b1, '{4'd8, 8'd255, 8'h00, 8'h00, 8'h82, 8'h08, 7'd96}},
        '{22'd37083,   4'd6,  1'b0, '0},
        '{22'd37084,   4'd7,  1'b0, '0},
        '{22'd55624,   4'd8,  1'b0, '0},
        '{22'd55625,   4'd1,  1'b0, '0},
        '{22'd74166,   4'd6,  1'b0, '0},
        '{22'd74167,   4'd7,  1'b0, '0},
        '{22'd111249,  4'd8,  1'b0, '0},
        '{22'd111250,  4'd2,  1'b0, '0},
        '{22'd148333,  4'd6,  1'b0, '0},
        '{22'd148334,  4'd7,  1'b0, '0},
        '{22'd222499,  4'd8,  1'b0, '0},
        '{22'd222500,  4'd3,  1'b0, '0},
        '{22'd296666,  4'd6,  1'b0, '0},
        '{22'd296667,  4'd7,  1'b0, '0},
        '{22'd444999,  4'd8,  1'b0, '0},
        '{22'd445000,  4'd4,  1'b0, '0},
        '{22'd593333,  4'd6,  1'b0, '0},
        '{22'd593334,  4'd7,  1'b0, '0},
        '{22'h3FFFFF,  4'd15, 1'b0, '0},
        '{22'h2AAAAA,  4'd10, 1'b0, '0},
        '{22'h155555,  4'd5,  1'b0, '0}
    };

    pll_divider_setting_calc i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_crystal_khz     (cfg_crystal_khz),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_frequency_khz     (s_frequency_khz),
        .s_bandwidth_mhz     (s_bandwidth_mhz),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_count_nine_cycles (m_count_nine_cycles),
        .m_total_cycles      (m_total_cycles),
        .m_fraction_high     (m_fraction_high),
        .m_fraction_low      (m_fraction_low),
        .m_output_divider    (m_output_divider),
        .m_mode_byte         (m_mode_byte),
        .m_vco_multiplier    (m_vco_multiplier)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Work out the register bytes that one tuning request should produce
    function automatic pdsc_pkg::res_t calc_pll_setting(
            input logic [pdsc_pkg::FREQ_W-1:0]    freq,
            input logic [pdsc_pkg::BW_W-1:0]      bw,
            input logic [pdsc_pkg::CRYSTAL_W-1:0] xtal);
        pdsc_pkg::res_t r;
        int unsigned    sel;
        logic [63:0]    vco;
        logic [63:0]    half;
        logic [63:0]    quarter;
        logic [63:0]    quo;
        logic [63:0]    rem;
        logic [63:0]    frac_wide;
        logic [15:0]    xdiv;
        logic [15:0]    frac;
        logic [7:0]     mode;

        // Scan from the smallest multiplier up so the largest one that fits wins
        sel = pdsc_pkg::NUM_MULT - 1;
        for (int i = pdsc_pkg::NUM_MULT - 2; i >= 0; i--) begin
            if (64'(freq) * 64'(VCO_MULT[i]) < 64'(pdsc_pkg::VCO_LIMIT))
                sel = i;
        end
        vco = 64'(freq) * 64'(VCO_MULT[sel]);

        // Half crystal of zero divides as one; the quarter stays as it is
        half = 64'(xtal) / 2;
        if (half == 0)
            half = 1;
        quarter = 64'(xtal) / 4;

        quo  = vco / half;
        rem  = vco - quo * half;
        xdiv = quo[15:0];
        if (rem >= quarter)
            xdiv = xdiv + 16'd1;

        // Borrow one total cycle when the count-to-9 part is below two
        if (xdiv[2:0] < 3'd2) begin
            r.count_nine_cycles = 4'(xdiv[2:0]) + 4'd8;
            r.total_cycles      = xdiv[10:3] - 8'd1;
        end else begin
            r.count_nine_cycles = 4'(xdiv[2:0]);
            r.total_cycles      = xdiv[10:3];
        end

        frac_wide = (rem << pdsc_pkg::FRAC_W) / half;
        frac      = frac_wide[15:0];
        if (frac >= 16'd16384)
            frac = frac + 16'd32768;
        r.fraction_high = frac[15:8];
        r.fraction_low  = frac[7:0];

        mode = pdsc_pkg::MODE_HIGH_BAND | ((sel % 2 == 1) ? pdsc_pkg::MODE_DIV3 : 8'h00);
        if (bw == pdsc_pkg::BW_SEL_6)
            mode[7:6] = pdsc_pkg::BW_CODE_6MHZ;
        else if (bw == pdsc_pkg::BW_SEL_7)
            mode[7:6] = pdsc_pkg::BW_CODE_7MHZ;
        else
            mode[7:6] = pdsc_pkg::BW_CODE_8MHZ;

        r.output_divider = ODIV_SEL[sel / 2];
        r.mode_byte      = mode;
        r.vco_multiplier = 7'(VCO_MULT[sel]);
        return r;
    endfunction

    // Draw a wait count: none during a calm stretch, else up to MAX_WAIT
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Drive one request transaction and record its expected settings on acceptance.
    // Valid is only dropped when a gap follows, so it never toggles within one step.
    task automatic send_request(input logic [pdsc_pkg::FREQ_W-1:0] freq,
                                input logic [pdsc_pkg::BW_W-1:0] bw,
                                input bit typed, input pdsc_pkg::res_t typed_res);
        int gap;
        if ($urandom_range(0, 23) == 0)
            send_calm = !send_calm;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_frequency_khz <= freq;
        s_bandwidth_mhz <= bw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_settings.push_back(typed ? typed_res : calc_pll_setting(freq, bw, crystal_khz));
    endtask

    // Write the crystal register; the caller makes sure the pipeline is empty
    task automatic write_crystal(input logic [pdsc_pkg::CRYSTAL_W-1:0] xtal);
        cfg_valid       <= 1'b1;
        cfg_crystal_khz <= xtal;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        crystal_khz  = xtal;
    endtask

    // Stimulus: reset, directed table, then random phases per crystal setting
    initial begin : stimulus
        logic [pdsc_pkg::CRYSTAL_W-1:0] xtal;
        logic [pdsc_pkg::FREQ_W-1:0]    freq;
        int                             k;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r])
            send_request(dir_rows[r].freq, dir_rows[r].bw, dir_rows[r].typed, dir_rows[r].want);
        s_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Hold the register write until every result has come back
            while (pending_settings.size() != 0) @(posedge aclk);
            if (ph < FIXED_PHASES)
                xtal = CRYSTAL_PLAN[ph];
            else if (ph == FIXED_PHASES)
                xtal = 16'($urandom_range(8000, 40000));
            else
                xtal = 16'($urandom_range(0, 65535));
            write_crystal(xtal);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Mix full-range, typical, boundary and tiny frequencies
                case ($urandom_range(0, 3))
                    0: freq = 22'($urandom);
                    1: freq = 22'($urandom_range(0, 600000));
                    2: begin
                        k    = $urandom_range(0, pdsc_pkg::NUM_MULT - 2);
                        freq = 22'(int'((pdsc_pkg::VCO_LIMIT - 1) / VCO_MULT[k])
                                   + $urandom_range(0, 3) - 1);
                    end
                    default: freq = 22'($urandom_range(0, 3000));
                endcase
                send_request(freq, 4'($urandom_range(0, 15)), 1'b0, '0);
            end
            s_valid <= 1'b0;
        end

        // Drain, then give stray results a chance to show up
        while (pending_settings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_settings.size() != 0) begin
            fail_count++;
            $display("ERROR: %0d expected results never arrived", pending_settings.size());
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: draw a stall before each transaction, then hold ready until it moves
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 23) == 0)
                recv_calm = !recv_calm;
            gap = draw_wait(recv_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Compare every accepted result with the oldest pending expectation
    always @(posedge aclk) begin : result_check
        pdsc_pkg::res_t got_res;
        pdsc_pkg::res_t want_res;
        if (aresetn && m_valid && m_ready) begin
            got_res = '{m_count_nine_cycles, m_total_cycles, m_fraction_high,
                        m_fraction_low, m_output_divider, m_mode_byte, m_vco_multiplier};
            if (pending_settings.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: result with nothing expected: total %0d cnt9 %0d",
                             got_res.total_cycles, got_res.count_nine_cycles);
            end else begin
                want_res = pending_settings.pop_front();
                if (got_res !== want_res) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"ERROR: mismatch (exp/got) cnt9 %0d/%0d total %0d/%0d ",
                                  "frac %h%h/%h%h odiv %h/%h mode %h/%h mult %0d/%0d"},
                                 want_res.count_nine_cycles, got_res.count_nine_cycles,
                                 want_res.total_cycles, got_res.total_cycles,
                                 want_res.fraction_high, want_res.fraction_low,
                                 got_res.fraction_high, got_res.fraction_low,
                                 want_res.output_divider, got_res.output_divider,
                                 want_res.mode_byte, got_res.mode_byte,
                                 want_res.vco_multiplier, got_res.vco_multiplier);
                end
            end
        end
    end

    // Watchdog: drop the run if it stalls past a generous cycle budget
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
